/* design/rycc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rycc_pkg
// Shared types, widths and fixed-point coefficients of the RGB / YCbCr
// pixel converter.
// ----------------------------------------------------------------------------
package rycc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int PIX_W     = 8;
   localparam int OPND_W    = PIX_W + 1;
   localparam int COEF_W    = FRAC_BITS + 3;
   localparam int PROD_W    = OPND_W + COEF_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int TRUNC_W   = SUM_W - FRAC_BITS;
   localparam int ADJ_W     = TRUNC_W + 1;
   localparam int TAPS      = 3;

   localparam longint unsigned MILLION = 64'd1000000;

   // magnitudes rounded to nearest, half away from zero
   localparam longint unsigned K_CR_R  = ((64'd1407500 << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_CB_G  = ((64'd345500  << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_CR_G  = ((64'd716900  << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_CB_B  = ((64'd1779000 << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_Y_R   = ((64'd299000  << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_Y_G   = ((64'd587000  << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_Y_B   = ((64'd114000  << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_CB_R  = ((64'd168736  << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_CB_GN = ((64'd331264  << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_CR_GN = ((64'd418688  << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_CR_BN = ((64'd81312   << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_HALF  = ((64'd500000  << FRAC_BITS) + MILLION / 2) / MILLION;
   localparam longint unsigned K_ONE   = 64'd1 << FRAC_BITS;

   typedef logic signed [OPND_W-1:0]  opnd_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [ADJ_W-1:0]   adj_type;
   typedef logic        [PIX_W-1:0]   pix_type;
   typedef coef_type    [TAPS-1:0]    coef_trio_type;

   localparam opnd_type CHROMA_MID = opnd_type'(128);
   localparam adj_type  ADJ_MID    = adj_type'(128);
   localparam adj_type  ADJ_MAX    = adj_type'(255);
   localparam sum_type  TRUNC_BIAS = sum_type'(K_ONE - 64'd1);

   typedef enum logic {
      MODE_TO_YCC = 1'b0,
      MODE_TO_RGB = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      LANE_FIRST  = 2'd0,
      LANE_SECOND = 2'd1,
      LANE_THIRD  = 2'd2
   } lane_type;

   typedef struct packed {
      logic prod;
      logic sum;
      logic pix;
   } adv_type;

   function automatic coef_type pos(input longint unsigned k);
      return coef_type'(k);
   endfunction

   function automatic coef_type neg(input longint unsigned k);
      return -coef_type'(k);
   endfunction

   // tap 0 weighs in_first, tap 1 in_second, tap 2 in_third
   function automatic coef_trio_type lane_coefs(input mode_type mode, input lane_type lane);
      coef_trio_type k;
      k = '0;
      case ({mode, lane})
         {MODE_TO_YCC, LANE_FIRST}: begin
            k[0] = pos(K_Y_R);   k[1] = pos(K_Y_G);    k[2] = pos(K_Y_B);
         end
         {MODE_TO_YCC, LANE_SECOND}: begin
            k[0] = neg(K_CB_R);  k[1] = neg(K_CB_GN);  k[2] = pos(K_HALF);
         end
         {MODE_TO_YCC, LANE_THIRD}: begin
            k[0] = pos(K_HALF);  k[1] = neg(K_CR_GN);  k[2] = neg(K_CR_BN);
         end
         {MODE_TO_RGB, LANE_FIRST}: begin
            k[0] = pos(K_ONE);   k[1] = '0;            k[2] = pos(K_CR_R);
         end
         {MODE_TO_RGB, LANE_SECOND}: begin
            k[0] = pos(K_ONE);   k[1] = neg(K_CB_G);   k[2] = neg(K_CR_G);
         end
         {MODE_TO_RGB, LANE_THIRD}: begin
            k[0] = pos(K_ONE);   k[1] = pos(K_CB_B);   k[2] = '0;
         end
         default: begin
            k = '0;
         end
      endcase
      return k;
   endfunction

endpackage

/* design/rycc_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rycc_lane
// One output component: three products, their sum, then truncation toward
// zero, chroma offset and saturation to 8 bits, one register stage each.
// ----------------------------------------------------------------------------
module rycc_lane (
   input  logic                   clock,
   input  rycc_pkg::adv_type       adv,
   input  rycc_pkg::opnd_type      opnd0,
   input  rycc_pkg::opnd_type      opnd1,
   input  rycc_pkg::opnd_type      opnd2,
   input  rycc_pkg::coef_trio_type coefs,
   input  logic                   offset,
   output rycc_pkg::pix_type       pix,
   output logic                   clip
);

   rycc_pkg::prod_type prod0_ff, prod1_ff, prod2_ff;
   rycc_pkg::prod_type prod0_in, prod1_in, prod2_in;
   rycc_pkg::sum_type  sum_ff, sum_in;
   rycc_pkg::pix_type  pix_ff, pix_in;
   logic               clip_ff, clip_in;
   rycc_pkg::sum_type  biased;
   rycc_pkg::adj_type  adj;

   always_comb begin
      prod0_in = opnd0 * $signed(coefs[0]);
      prod1_in = opnd1 * $signed(coefs[1]);
      prod2_in = opnd2 * $signed(coefs[2]);
   end

   always_comb begin
      sum_in = rycc_pkg::sum_type'(prod0_ff) + rycc_pkg::sum_type'(prod1_ff)
             + rycc_pkg::sum_type'(prod2_ff);
   end

   // truncation toward zero, then chroma offset and saturation
   always_comb begin
      biased = sum_ff + (sum_ff[rycc_pkg::SUM_W-1] ? rycc_pkg::TRUNC_BIAS : '0);
      adj    = rycc_pkg::adj_type'($signed(biased[rycc_pkg::SUM_W-1:rycc_pkg::FRAC_BITS]))
             + (offset ? rycc_pkg::ADJ_MID : '0);
      if (adj < 0) begin
         pix_in  = '0;
         clip_in = 1'b1;
      end else if (adj > rycc_pkg::ADJ_MAX) begin
         pix_in  = '1;
         clip_in = 1'b1;
      end else begin
         pix_in  = adj[rycc_pkg::PIX_W-1:0];
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.prod) begin
         prod0_ff <= prod0_in;
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
      end
      if (adv.sum) begin
         sum_ff <= sum_in;
      end
      if (adv.pix) begin
         pix_ff  <= pix_in;
         clip_ff <= clip_in;
      end
   end

   assign pix  = pix_ff;
   assign clip = clip_ff;

endmodule

/* design/rgb_ycbcr_pixel_converter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_ycbcr_pixel_converter_top
// Converts one 8-bit-per-component pixel per beat between RGB and full-range
// BT.601 YCbCr in fixed point, with saturation and a clip flag.
// ----------------------------------------------------------------------------
// The converter takes one pixel every clock cycle while the result side
// does not stall and passes it through an input register, a multiplier
// stage, an adder stage and a truncate/saturate stage that doubles as the
// output register. Each stage has its own valid bit and loads whenever it is
// empty or the stage after it moves, so bubbles are squeezed out and a stall
// on the result side reaches req_stall only once the pipeline is full. Mode
// travels with every pixel, so successive pixels may use different directions.
module rgb_ycbcr_pixel_converter_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [7:0]             req_in_first,
   input  logic [7:0]             req_in_second,
   input  logic [7:0]             req_in_third,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_first,
   output logic [7:0]             rsp_out_second,
   output logic [7:0]             rsp_out_third,
   output logic                   rsp_clipped
);

   logic                valid_a_ff, valid_b_ff, valid_c_ff, valid_d_ff;
   logic                en_a, en_b, en_c, en_d;
   rycc_pkg::adv_type   adv;

   rycc_pkg::mode_type  mode_a_ff, mode_b_ff, mode_c_ff, mode_a_in;
   rycc_pkg::opnd_type  opnd0_ff, opnd1_ff, opnd2_ff;
   rycc_pkg::opnd_type  opnd0_in, opnd1_in, opnd2_in;
   logic                chroma_offset;
   logic [2:0]          clips;

   always_comb begin
      en_d = !valid_d_ff || !rsp_stall;
      en_c = !valid_c_ff || en_d;
      en_b = !valid_b_ff || en_c;
      en_a = !valid_a_ff || en_b;
      adv.prod = en_b;
      adv.sum  = en_c;
      adv.pix  = en_d;
   end

   assign req_stall = !en_a;
   assign rsp_valid = valid_d_ff;

   always_comb begin
      mode_a_in = rycc_pkg::mode_type'(req_mode);
      opnd0_in  = rycc_pkg::opnd_type'({1'b0, req_in_first});
      opnd1_in  = rycc_pkg::opnd_type'({1'b0, req_in_second});
      opnd2_in  = rycc_pkg::opnd_type'({1'b0, req_in_third});
      if (mode_a_in == rycc_pkg::MODE_TO_RGB) begin
         opnd1_in = opnd1_in - rycc_pkg::CHROMA_MID;
         opnd2_in = opnd2_in - rycc_pkg::CHROMA_MID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
      end else begin
         if (en_a) begin
            valid_a_ff <= req_valid;
         end
         if (en_b) begin
            valid_b_ff <= valid_a_ff;
         end
         if (en_c) begin
            valid_c_ff <= valid_b_ff;
         end
         if (en_d) begin
            valid_d_ff <= valid_c_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         mode_a_ff <= mode_a_in;
         opnd0_ff  <= opnd0_in;
         opnd1_ff  <= opnd1_in;
         opnd2_ff  <= opnd2_in;
      end
      if (en_b) begin
         mode_b_ff <= mode_a_ff;
      end
      if (en_c) begin
         mode_c_ff <= mode_b_ff;
      end
   end

   assign chroma_offset = (mode_c_ff == rycc_pkg::MODE_TO_YCC);

   rycc_lane u_lane_first (
      .clock (clock),
      .adv   (adv),
      .opnd0 (opnd0_ff),
      .opnd1 (opnd1_ff),
      .opnd2 (opnd2_ff),
      .coefs (rycc_pkg::lane_coefs(mode_a_ff, rycc_pkg::LANE_FIRST)),
      .offset(1'b0),
      .pix   (rsp_out_first),
      .clip  (clips[0])
   );

   rycc_lane u_lane_second (
      .clock (clock),
      .adv   (adv),
      .opnd0 (opnd0_ff),
      .opnd1 (opnd1_ff),
      .opnd2 (opnd2_ff),
      .coefs (rycc_pkg::lane_coefs(mode_a_ff, rycc_pkg::LANE_SECOND)),
      .offset(chroma_offset),
      .pix   (rsp_out_second),
      .clip  (clips[1])
   );

   rycc_lane u_lane_third (
      .clock (clock),
      .adv   (adv),
      .opnd0 (opnd0_ff),
      .opnd1 (opnd1_ff),
      .opnd2 (opnd2_ff),
      .coefs (rycc_pkg::lane_coefs(mode_a_ff, rycc_pkg::LANE_THIRD)),
      .offset(chroma_offset),
      .pix   (rsp_out_third),
      .clip  (clips[2])
   );

   assign rsp_clipped = |clips;

endmodule

/* design/rycc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rycc_checker
// Port-level checks of the pixel converter: reset, latency, held results
// and clip flag consistency.
// ----------------------------------------------------------------------------
module rycc_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_first,
   input  logic [7:0] rsp_out_second,
   input  logic [7:0] rsp_out_third,
   input  logic       rsp_clipped
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted beat did not reach the result side in four cycles");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_out_first)
         && $stable(rsp_out_second) && $stable(rsp_out_third) && $stable(rsp_clipped))
      else $error("stalled result beat changed");

   a_clip_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |-> (rsp_out_first == 8'd0 || rsp_out_first == 8'd255
         || rsp_out_second == 8'd0 || rsp_out_second == 8'd255
         || rsp_out_third == 8'd0 || rsp_out_third == 8'd255))
      else $error("clip flag set without a saturated component");

endmodule

bind rgb_ycbcr_pixel_converter_top rycc_checker u_rycc_checker (.*);
